>>> hw/rtl/lebuf_pkg.sv
// Package for the line edit buffer: command codes, sequencer states,
// the default buffer depth and the word-character classifier.
// No dependencies.
package lebuf_pkg;

   // Default number of character slots
   localparam int BUF_DEPTH_DEF = 64;

   // Underscore joins words like a letter does
   localparam logic [7:0] WORD_JOIN = 8'h5F;

   typedef enum logic [3:0] {
      CMD_READ      = 4'd0,
      CMD_INSERT    = 4'd1,
      CMD_HOME      = 4'd2,
      CMD_END       = 4'd3,
      CMD_LEFT      = 4'd4,
      CMD_RIGHT     = 4'd5,
      CMD_WORDLEFT  = 4'd6,
      CMD_WORDRIGHT = 4'd7,
      CMD_BACKSP    = 4'd8,
      CMD_DEL       = 4'd9,
      CMD_WORDBACK  = 4'd10,
      CMD_WORDDEL   = 4'd11,
      CMD_SUBMIT    = 4'd12
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_PB_READ,
      ST_PB_TEST,
      ST_NB_READ,
      ST_NB_TEST,
      ST_SH_READ,
      ST_SH_WRITE,
      ST_INS_READ,
      ST_INS_WRITE,
      ST_DONE
   } state_type;

   // ASCII letters, digits and underscore
   function automatic logic is_word(input logic [7:0] c);
      is_word = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A) || (c == WORD_JOIN);
   endfunction

endpackage

>>> hw/rtl/line_edit_buffer.sv
// Line edit buffer: a one-line text store with cursor, word moves and deletes. Uses lebuf_pkg.
// Cursor moves, submit and unused codes go from decode straight to the result; a read waits
// for the registered memory read; an insert moves the tail up one character at a time, and
// scans and shifts use a read state and a test or write state per character visited or moved.
// One request at a time: req_stall stays high until the result is registered and the sequencer is idle.
// Synchronous reset empties the buffer and homes the cursor; no clearing pass.
module line_edit_buffer
   import lebuf_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_cmd,
   input  logic [7:0] req_char_in,
   input  logic [5:0] req_read_index,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_cursor_pos,
   output logic [6:0] rsp_text_length,
   output logic       rsp_text_changed,
   output logic       rsp_submit_fired,
   output logic       rsp_insert_refused,
   output logic [7:0] rsp_read_char
);

   localparam int LW = $clog2(BUF_DEPTH + 1);   // length / cursor width
   localparam int AW = $clog2(BUF_DEPTH);       // memory address width
   localparam int RW = (LW > 6) ? LW : 6;       // read index compare width

   // character memory
   logic [7:0]    char_store [BUF_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // sequencer state
   state_type     state_ff, state_in;
   cmd_type       cmd_ff;
   logic [7:0]    char_ff;
   logic [5:0]    ridx_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] ptr_ff, ptr_in;   // scan pointer, also insert destination
   logic [LW-1:0] src_ff, src_in;
   logic          phase_ff, phase_in;
   logic          changed_ff, changed_in;
   logic          fired_ff, fired_in;
   logic          refused_ff, refused_in;
   logic [7:0]    rchar_ff, rchar_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    out_cur_ff, out_cur_in;
   logic [6:0]    out_len_ff, out_len_in;
   logic          out_changed_ff, out_changed_in;
   logic          out_fired_ff, out_fired_in;
   logic          out_refused_ff, out_refused_in;
   logic [7:0]    out_rchar_ff, out_rchar_in;

   logic          req_take;
   logic          rd_word;
   logic          scan_done;
   logic [LW-1:0] scan_pos;
   logic [LW-1:0] ptr_dec;
   logic [LW-1:0] ptr_inc;
   logic          ridx_hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rd_word   = is_word(rd_data_ff);
   assign ptr_dec   = ptr_ff - LW'(1);
   assign ptr_inc   = ptr_ff + LW'(1);
   assign ridx_hit  = (RW'(ridx_ff) < RW'(len_ff));

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_pos     = out_cur_ff;
   assign rsp_text_length    = out_len_ff;
   assign rsp_text_changed   = out_changed_ff;
   assign rsp_submit_fired   = out_fired_ff;
   assign rsp_insert_refused = out_refused_ff;
   assign rsp_read_char      = out_rchar_ff;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_store[wr_addr] <= wr_data;
      end
      rd_data_ff <= char_store[rd_addr];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= cmd_type'(req_cmd);
         char_ff <= req_char_in;
         ridx_ff <= req_read_index;
      end
   end

   // control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      src_ff         <= src_in;
      phase_ff       <= phase_in;
      changed_ff     <= changed_in;
      fired_ff       <= fired_in;
      refused_ff     <= refused_in;
      rchar_ff       <= rchar_in;
      out_cur_ff     <= out_cur_in;
      out_len_ff     <= out_len_in;
      out_changed_ff <= out_changed_in;
      out_fired_ff   <= out_fired_in;
      out_refused_ff <= out_refused_in;
      out_rchar_ff   <= out_rchar_in;
   end

   // sequencer: next state and memory port control
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      cur_in         = cur_ff;
      ptr_in         = ptr_ff;
      src_in         = src_ff;
      phase_in       = phase_ff;
      changed_in     = changed_ff;
      fired_in       = fired_ff;
      refused_in     = refused_ff;
      rchar_in       = rchar_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_cur_in     = out_cur_ff;
      out_len_in     = out_len_ff;
      out_changed_in = out_changed_ff;
      out_fired_in   = out_fired_ff;
      out_refused_in = out_refused_ff;
      out_rchar_in   = out_rchar_ff;
      rd_addr        = ptr_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = ptr_ff[AW-1:0];
      wr_data        = rd_data_ff;
      scan_done      = 1'b0;
      scan_pos       = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end

         // decode the captured command
         ST_EXEC: begin
            changed_in = 1'b0;
            fired_in   = 1'b0;
            refused_in = 1'b0;
            rchar_in   = 8'h00;
            phase_in   = 1'b0;
            state_in   = ST_DONE;
            unique case (cmd_ff) inside
               CMD_READ: begin
                  rd_addr  = AW'(ridx_ff);
                  state_in = ST_RD_WAIT;
               end
               CMD_INSERT: begin
                  if (char_ff != 8'h00) begin
                     if (len_ff == LW'(BUF_DEPTH)) begin
                        refused_in = 1'b1;
                     end else begin
                        ptr_in   = len_ff;
                        state_in = ST_INS_READ;
                     end
                  end
               end
               CMD_HOME: cur_in = '0;
               CMD_END:  cur_in = len_ff;
               CMD_LEFT: begin
                  if (cur_ff != '0) cur_in = cur_ff - LW'(1);
               end
               CMD_RIGHT: begin
                  if (cur_ff < len_ff) cur_in = cur_ff + LW'(1);
               end
               CMD_WORDLEFT, CMD_WORDBACK: begin
                  if (cur_ff == '0) begin
                     scan_done = 1'b1;
                     scan_pos  = '0;
                  end else begin
                     ptr_in   = cur_ff - LW'(1);
                     state_in = ST_PB_READ;
                  end
               end
               CMD_WORDRIGHT, CMD_WORDDEL: begin
                  ptr_in   = cur_ff;
                  state_in = ST_NB_READ;
               end
               CMD_BACKSP: begin
                  if (cur_ff != '0) begin
                     ptr_in     = cur_ff - LW'(1);
                     src_in     = cur_ff;
                     cur_in     = cur_ff - LW'(1);
                     changed_in = 1'b1;
                     state_in   = ST_SH_READ;
                  end
               end
               CMD_DEL: begin
                  if (cur_ff < len_ff) begin
                     ptr_in     = cur_ff;
                     src_in     = cur_ff + LW'(1);
                     changed_in = 1'b1;
                     state_in   = ST_SH_READ;
                  end
               end
               CMD_SUBMIT: fired_in = (len_ff != '0);
               default: ;
            endcase
         end

         ST_RD_WAIT: begin
            rchar_in = ridx_hit ? rd_data_ff : 8'h00;
            state_in = ST_DONE;
         end

         // backward word scan
         ST_PB_READ: begin
            rd_addr  = ptr_ff[AW-1:0];
            state_in = ST_PB_TEST;
         end
         ST_PB_TEST: begin
            if (ptr_ff == '0) begin
               // stopped at the first slot: step forward unless it is a word char
               scan_done = 1'b1;
               scan_pos  = rd_word ? LW'(0) : LW'(1);
            end else if (!phase_ff || rd_word) begin
               if (rd_word) phase_in = 1'b1;
               ptr_in   = ptr_dec;
               state_in = ST_PB_READ;
            end else begin
               scan_done = 1'b1;
               scan_pos  = ptr_inc;
            end
         end

         // forward word scan
         ST_NB_READ: begin
            rd_addr = ptr_ff[AW-1:0];
            if (ptr_ff >= len_ff) begin
               scan_done = 1'b1;
               scan_pos  = ptr_ff;
            end else begin
               state_in = ST_NB_TEST;
            end
         end
         ST_NB_TEST: begin
            if (phase_ff && rd_word) begin
               scan_done = 1'b1;
               scan_pos  = ptr_ff;
            end else begin
               if (!rd_word) phase_in = 1'b1;
               ptr_in   = ptr_inc;
               state_in = ST_NB_READ;
            end
         end

         // close the gap: copy src down to ptr until src reaches the end
         ST_SH_READ: begin
            rd_addr = src_ff[AW-1:0];
            if (src_ff >= len_ff) begin
               len_in   = ptr_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SH_WRITE;
            end
         end
         ST_SH_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[AW-1:0];
            wr_data  = rd_data_ff;
            ptr_in   = ptr_inc;
            src_in   = src_ff + LW'(1);
            state_in = ST_SH_READ;
         end

         // open a slot at the cursor, moving the tail up from the end
         ST_INS_READ: begin
            rd_addr = ptr_dec[AW-1:0];
            if (ptr_ff == cur_ff) begin
               wr_en      = 1'b1;
               wr_addr    = cur_ff[AW-1:0];
               wr_data    = char_ff;
               len_in     = len_ff + LW'(1);
               cur_in     = cur_ff + LW'(1);
               changed_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_INS_WRITE;
            end
         end
         ST_INS_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[AW-1:0];
            wr_data  = rd_data_ff;
            ptr_in   = ptr_dec;
            state_in = ST_INS_READ;
         end

         // hand the result over once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               out_cur_in     = 7'(cur_ff);
               out_len_in     = 7'(len_ff);
               out_changed_in = changed_ff;
               out_fired_in   = fired_ff;
               out_refused_in = refused_ff;
               out_rchar_in   = rchar_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // scan finished: move the cursor or start a word delete
      if (scan_done) begin
         state_in = ST_DONE;
         if (cmd_ff == CMD_WORDLEFT || cmd_ff == CMD_WORDRIGHT) begin
            cur_in = scan_pos;
         end else if (cmd_ff == CMD_WORDBACK) begin
            if (scan_pos < cur_ff) begin
               ptr_in     = scan_pos;
               src_in     = cur_ff;
               cur_in     = scan_pos;
               changed_in = 1'b1;
               state_in   = ST_SH_READ;
            end
         end else if (scan_pos > cur_ff) begin
            ptr_in     = cur_ff;
            src_in     = scan_pos;
            changed_in = 1'b1;
            state_in   = ST_SH_READ;
         end
      end
   end

   // checks
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= len_ff) else $error("cursor beyond text length");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(BUF_DEPTH)) else $error("text length beyond buffer depth");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_refused_ff && out_changed_ff))
      else $error("refused insert reported a change");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("sequencer not idle after reset");

endmodule
